/* rtl/core/hmng_pkg.sv */
// shared types and constants of the heightmap normal generator
// no dependencies; every other file of the block refers to it by scoped names
package hmng_pkg;

  localparam int MaxRowLength = 1024;
  localparam int ColW         = $clog2(MaxRowLength);
  localparam int LenW         = 11;
  localparam int RowW         = 16;
  localparam int HeightBits   = 16;
  localparam int CompW        = 16;
  localparam int MagW         = 50;
  localparam int JobDepth     = 4;
  localparam int JobPtrW      = $clog2(JobDepth);
  localparam int JobCntW      = $clog2(JobDepth + 1);

  localparam logic signed [CompW-1:0] Q14One = 16'sd16384;

  typedef enum logic [2:0] {
    CFG_ROW_LENGTH     = 3'd0,
    CFG_ROW_COUNT      = 3'd1,
    CFG_CELL_SIZE_X    = 3'd2,
    CFG_CELL_SIZE_Z    = 3'd3,
    CFG_HEIGHT_SCALE   = 3'd4,
    CFG_NORMALS_ENABLE = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LenW-1:0]    row_length;
    logic [RowW-1:0]    row_count;
    logic [15:0]        cell_size_x;
    logic [15:0]        cell_size_z;
    logic signed [15:0] height_scale;
    logic               normals_enable;
  } cfg_t;

  typedef struct packed {
    logic [ColW-1:0]              col;
    logic [RowW-1:0]              row;
    logic signed [HeightBits-1:0] lf;
    logic signed [HeightBits-1:0] rt;
    logic signed [HeightBits-1:0] dn;
    logic signed [HeightBits-1:0] up;
    logic                         last;
  } job_t;

endpackage

/* rtl/core/hmng_front.sv */
// front end: sample acceptance, line stores, window and grid counters
// emits one neighbourhood job per grid point; depends on hmng_pkg
module hmng_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  hmng_pkg::cfg_t                        cfg_i,
  input  logic                                  push_i,
  input  logic signed [hmng_pkg::HeightBits-1:0] height_i,
  output logic                                  full_o,
  output hmng_pkg::job_t                        job_o,
  output logic                                  job_push_o,
  input  logic                                  job_full_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_EMIT = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;

  logic signed [hmng_pkg::HeightBits-1:0] prev_mem  [hmng_pkg::MaxRowLength];
  logic signed [hmng_pkg::HeightBits-1:0] prev2_mem [hmng_pkg::MaxRowLength];
  logic signed [hmng_pkg::HeightBits-1:0] prev_a_q, prev_b_q, p2_a_q, p2_b_q;

  logic [hmng_pkg::ColW-1:0] col_cnt_q, c_w, c_q;
  logic [hmng_pkg::RowW-1:0] row_cnt_q, r_w, r_q, rows_w;
  logic [hmng_pkg::LenW-1:0] len_w;
  logic                      lastc_w, lastr_w, lastc_q, lastr_q;
  logic signed [hmng_pkg::HeightBits-1:0] h_q, win_left_q, win_m1_q, win_m2_q;

  hmng_pkg::job_t job_q [3];
  hmng_pkg::job_t job_d [3];
  logic [2:0]     mask_q, mask_d;
  logic [1:0]     sel_w;

  always_comb begin
    len_w = cfg_i.row_length;
    if (len_w < hmng_pkg::LenW'(2)) begin
      len_w = hmng_pkg::LenW'(2);
    end else if (len_w > hmng_pkg::LenW'(hmng_pkg::MaxRowLength)) begin
      len_w = hmng_pkg::LenW'(hmng_pkg::MaxRowLength);
    end
    rows_w  = (cfg_i.row_count < 16'd2) ? 16'd2 : cfg_i.row_count;
    c_w     = ({1'b0, col_cnt_q} < len_w) ? col_cnt_q
                                          : hmng_pkg::ColW'(len_w - 1'b1);
    r_w     = (row_cnt_q < rows_w) ? row_cnt_q : rows_w - 16'd1;
    lastc_w = ({1'b0, c_w} == len_w - 1'b1);
    lastr_w = (r_w == rows_w - 16'd1);
  end

  // line stores, read every cycle at the current column
  always_ff @(posedge clk_i) begin
    prev_a_q <= prev_mem[c_w];
    prev_b_q <= prev_mem[hmng_pkg::ColW'(c_w + 1'b1)];
    p2_a_q   <= prev2_mem[c_w];
    p2_b_q   <= prev2_mem[hmng_pkg::ColW'(c_w - 1'b1)];
    if (state_q == F_CALC) begin
      prev_mem[c_q]  <= h_q;
      prev2_mem[c_q] <= prev_a_q;
    end
  end

  always_comb begin
    job_d[0].col  = c_q;
    job_d[0].row  = r_q - 16'd1;
    job_d[0].lf   = (c_q == '0) ? prev_a_q : win_left_q;
    job_d[0].rt   = lastc_q ? prev_a_q : prev_b_q;
    job_d[0].dn   = (r_q == 16'd1) ? prev_a_q : p2_a_q;
    job_d[0].up   = h_q;
    job_d[0].last = 1'b0;

    job_d[1].col  = c_q - 1'b1;
    job_d[1].row  = r_q;
    job_d[1].lf   = (c_q == hmng_pkg::ColW'(1)) ? win_m1_q : win_m2_q;
    job_d[1].rt   = h_q;
    job_d[1].dn   = p2_b_q;
    job_d[1].up   = win_m1_q;
    job_d[1].last = 1'b0;

    job_d[2].col  = c_q;
    job_d[2].row  = r_q;
    job_d[2].lf   = win_m1_q;
    job_d[2].rt   = h_q;
    job_d[2].dn   = prev_a_q;
    job_d[2].up   = h_q;
    job_d[2].last = 1'b1;

    mask_d = {lastr_q & lastc_q, lastr_q & (c_q != '0), r_q != '0};
  end

  always_comb begin
    if (mask_q[0]) begin
      sel_w = 2'd0;
    end else if (mask_q[1]) begin
      sel_w = 2'd1;
    end else begin
      sel_w = 2'd2;
    end
  end

  assign job_o      = job_q[sel_w];
  assign job_push_o = (state_q == F_EMIT) && !job_full_i;
  assign full_o     = (state_q != F_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        state_d = (mask_d != '0) ? F_EMIT : F_IDLE;
      end
      F_EMIT: begin
        if (!job_full_i && ((mask_q & ~(3'b001 << sel_w)) == '0)) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
      win_left_q <= '0;
      win_m1_q   <= '0;
      win_m2_q   <= '0;
      mask_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_CALC) begin
        mask_q     <= mask_d;
        win_left_q <= prev_a_q;
        win_m2_q   <= win_m1_q;
        win_m1_q   <= h_q;
        if (lastc_q) begin
          col_cnt_q <= '0;
          row_cnt_q <= lastr_q ? '0 : r_q + 16'd1;
        end else begin
          col_cnt_q <= c_q + 1'b1;
          row_cnt_q <= r_q;
        end
      end else if (job_push_o) begin
        mask_q <= mask_q & ~(3'b001 << sel_w);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      h_q     <= height_i;
      c_q     <= c_w;
      r_q     <= r_w;
      lastc_q <= lastc_w;
      lastr_q <= lastr_w;
    end
    if (state_q == F_CALC) begin
      job_q[0] <= job_d[0];
      job_q[1] <= job_d[1];
      job_q[2] <= job_d[2];
    end
  end

endmodule

/* rtl/core/hmng_fifo.sv */
// short job queue between the front end and the normal unit
// depends on hmng_pkg for the job type and depth
module hmng_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hmng_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output hmng_pkg::job_t data_o,
  output logic           empty_o
);

  hmng_pkg::job_t                mem_q [hmng_pkg::JobDepth];
  logic [hmng_pkg::JobPtrW-1:0]  wr_q, rd_q;
  logic [hmng_pkg::JobCntW-1:0]  cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == hmng_pkg::JobCntW'(hmng_pkg::JobDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/hmng_back.sv */
// normal unit: gradient products, range shift, iterative square root and
// restoring division to Q2.14, with an output register; depends on hmng_pkg
module hmng_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hmng_pkg::cfg_t                       cfg_i,
  input  hmng_pkg::job_t                       job_i,
  input  logic                                 job_empty_i,
  output logic                                 job_pop_o,
  output logic [hmng_pkg::ColW-1:0]            col_o,
  output logic [hmng_pkg::RowW-1:0]            row_o,
  output logic signed [hmng_pkg::CompW-1:0]    normal_x_o,
  output logic signed [hmng_pkg::CompW-1:0]    normal_y_o,
  output logic signed [hmng_pkg::CompW-1:0]    normal_z_o,
  output logic                                 last_of_grid_o,
  output logic                                 empty_o,
  input  logic                                 pop_i
);

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_MUL1  = 9'b000000010,
    B_MUL2  = 9'b000000100,
    B_NORM  = 9'b000001000,
    B_SQ    = 9'b000010000,
    B_SQRT  = 9'b000100000,
    B_DLOAD = 9'b001000000,
    B_DIV   = 9'b010000000,
    B_DONE  = 9'b100000000
  } bstate_e;

  bstate_e state_q;

  hmng_pkg::job_t job_q;
  logic signed [16:0] dx_w, dz_w;
  logic signed [32:0] dhx_q, dhz_q;
  logic [31:0]        cxz_w;
  logic [33:0]        ny_q;
  logic signed [49:0] px_w, pz_w, pxa_w, pza_w;
  logic [hmng_pkg::MagW-1:0] ax_q, ay_q, az_q, ax_w, az_w, mag_w;
  logic               sx_q, sz_q, neg_w, big_w;
  logic [1:0]         idx_q;
  logic [59:0]        sq_w;
  logic [61:0]        acc_q, acc_w;
  logic [63:0]        v_q, res_q, bit_q, t_w, res_w;
  logic [31:0]        len_q;
  logic [45:0]        rem_q, dv_q;
  logic [3:0]         k_q;
  logic [14:0]        q_q, qn_w;
  logic               ge_w;
  logic signed [hmng_pkg::CompW-1:0] qv_w, cx_q, cy_q, cz_q;
  logic               out_valid_q, load_w;

  assign dx_w  = $signed({job_q.rt[15], job_q.rt}) - $signed({job_q.lf[15], job_q.lf});
  assign dz_w  = $signed({job_q.up[15], job_q.up}) - $signed({job_q.dn[15], job_q.dn});
  assign cxz_w = 32'(cfg_i.cell_size_x) * 32'(cfg_i.cell_size_z);
  assign px_w  = $signed({1'b0, cfg_i.cell_size_z}) * dhx_q;
  assign pz_w  = $signed({1'b0, cfg_i.cell_size_x}) * dhz_q;
  assign pxa_w = px_w[49] ? -px_w : px_w;
  assign pza_w = pz_w[49] ? -pz_w : pz_w;
  assign ax_w  = hmng_pkg::MagW'({pxa_w, 1'b0});
  assign az_w  = hmng_pkg::MagW'({pza_w, 1'b0});
  assign big_w = (|ax_q[49:30]) | (|ay_q[49:30]) | (|az_q[49:30]);

  always_comb begin
    case (idx_q)
      2'd0: begin
        mag_w = ax_q;
        neg_w = sx_q;
      end
      2'd1: begin
        mag_w = ay_q;
        neg_w = 1'b0;
      end
      default: begin
        mag_w = az_q;
        neg_w = sz_q;
      end
    endcase
  end

  assign sq_w  = mag_w[29:0] * mag_w[29:0];
  assign acc_w = acc_q + 62'(sq_w);
  assign t_w   = res_q + bit_q;
  assign res_w = (v_q >= t_w) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
  assign ge_w  = (rem_q >= dv_q);
  assign qn_w  = ge_w ? (q_q | (15'(1) << k_q)) : q_q;
  assign qv_w  = neg_w ? -$signed({1'b0, qn_w}) : $signed({1'b0, qn_w});

  assign job_pop_o = (state_q == B_IDLE) && !job_empty_i;
  assign load_w    = (state_q == B_DONE) && (!out_valid_q || pop_i);
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
    end else begin
      if (load_w) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!job_empty_i) begin
            state_q <= B_MUL1;
          end
        end
        B_MUL1: state_q <= B_MUL2;
        B_MUL2: begin
          if (!cfg_i.normals_enable || ((ax_w | az_w) == '0 && ny_q == '0)) begin
            state_q <= B_DONE;
          end else begin
            state_q <= B_NORM;
          end
        end
        B_NORM: begin
          if (!big_w) begin
            idx_q   <= '0;
            state_q <= B_SQ;
          end
        end
        B_SQ: begin
          if (idx_q == 2'd2) begin
            state_q <= B_SQRT;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        B_SQRT: begin
          if (bit_q == 64'd1) begin
            idx_q   <= '0;
            state_q <= B_DLOAD;
          end
        end
        B_DLOAD: begin
          k_q     <= 4'd14;
          state_q <= B_DIV;
        end
        B_DIV: begin
          k_q <= k_q - 4'd1;
          if (k_q == '0) begin
            if (idx_q == 2'd2) begin
              state_q <= B_DONE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= B_DLOAD;
            end
          end
        end
        B_DONE: begin
          if (load_w) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_q <= job_i;
        end
      end
      B_MUL1: begin
        dhx_q <= dx_w * cfg_i.height_scale;
        dhz_q <= dz_w * cfg_i.height_scale;
        ny_q  <= {cxz_w, 2'b00};
      end
      B_MUL2: begin
        ax_q <= ax_w;
        ay_q <= hmng_pkg::MagW'(ny_q);
        az_q <= az_w;
        sx_q <= ~px_w[49];
        sz_q <= ~pz_w[49];
        cx_q <= '0;
        cy_q <= hmng_pkg::Q14One;
        cz_q <= '0;
        acc_q <= '0;
      end
      B_NORM: begin
        if (big_w) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
          az_q <= az_q >> 1;
        end
      end
      B_SQ: begin
        acc_q <= acc_w;
        if (idx_q == 2'd2) begin
          v_q   <= 64'(acc_w);
          res_q <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
        end
      end
      B_SQRT: begin
        if (v_q >= t_w) begin
          v_q <= v_q - t_w;
        end
        res_q <= res_w;
        bit_q <= bit_q >> 2;
        if (bit_q == 64'd1) begin
          len_q <= 32'(res_w);
        end
      end
      B_DLOAD: begin
        rem_q <= 46'({mag_w[29:0], 14'b0}) + 46'(len_q >> 1);
        dv_q  <= 46'({len_q, 14'b0});
        q_q   <= '0;
      end
      B_DIV: begin
        if (ge_w) begin
          rem_q <= rem_q - dv_q;
        end
        dv_q <= dv_q >> 1;
        q_q  <= qn_w;
        if (k_q == '0) begin
          case (idx_q)
            2'd0:    cx_q <= qv_w;
            2'd1:    cy_q <= qv_w;
            default: cz_q <= qv_w;
          endcase
        end
      end
      default: begin
      end
    endcase
    if (load_w) begin
      col_o          <= job_q.col;
      row_o          <= job_q.row;
      normal_x_o     <= cx_q;
      normal_y_o     <= cy_q;
      normal_z_o     <= cz_q;
      last_of_grid_o <= job_q.last;
    end
  end

endmodule

/* rtl/core/heightmap_normal_generator.sv */
// top level of the heightmap normal generator: configuration registers,
// front end, job queue and normal unit; depends on hmng_pkg and all hmng_ modules
//
// usage:
//   samples enter in raster order through push_i/full_o/height_i; a beat is
//   taken when push_i is high and full_o low. full_o then stays high while
//   the front end updates the line stores and hands up to three jobs to a
//   four-entry job queue, and also while that queue is full.
//   normals leave through empty_o/pop_i; the oldest result sits on the result
//   ports while empty_o is low and a beat completes when pop_i is high.
//   the normal unit runs setup, range shift, squaring, square root, division
//   and a result register load; with normals off or a zero vector it skips
//   from setup to the load. that unit sets the sustained rate: it takes the
//   next job only once its result is loaded. the normal of (c, r-1) follows
//   sample (c, r); the last row also gives its own normals, the final one with
//   last_of_grid_o. configuration writes use cfg_valid_i/cfg_ready_o, are
//   always taken, and the user must make them only while the block is idle;
//   the block does not enforce this. reset clears counters, window and queues
//   and loads the register defaults; line stores hold garbage until written.
//   when pop_i stays low the unit and job queue fill and full_o stays high.
module heightmap_normal_generator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic signed [hmng_pkg::HeightBits-1:0] height_i,
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic [hmng_pkg::ColW-1:0]            col_o,
  output logic [hmng_pkg::RowW-1:0]            row_o,
  output logic signed [hmng_pkg::CompW-1:0]    normal_x_o,
  output logic signed [hmng_pkg::CompW-1:0]    normal_y_o,
  output logic signed [hmng_pkg::CompW-1:0]    normal_z_o,
  output logic                                 last_of_grid_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);

  hmng_pkg::cfg_t cfg_q;
  hmng_pkg::job_t fe_job, jq_job;
  logic           jq_push, jq_full, jq_pop, jq_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_length     <= hmng_pkg::LenW'(2);
      cfg_q.row_count      <= 16'd2;
      cfg_q.cell_size_x    <= 16'd256;
      cfg_q.cell_size_z    <= 16'd256;
      cfg_q.height_scale   <= 16'sd256;
      cfg_q.normals_enable <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hmng_pkg::CFG_ROW_LENGTH:     cfg_q.row_length     <= cfg_data_i[10:0];
        hmng_pkg::CFG_ROW_COUNT:      cfg_q.row_count      <= cfg_data_i;
        hmng_pkg::CFG_CELL_SIZE_X:    cfg_q.cell_size_x    <= cfg_data_i;
        hmng_pkg::CFG_CELL_SIZE_Z:    cfg_q.cell_size_z    <= cfg_data_i;
        hmng_pkg::CFG_HEIGHT_SCALE:   cfg_q.height_scale   <= $signed(cfg_data_i);
        hmng_pkg::CFG_NORMALS_ENABLE: cfg_q.normals_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  hmng_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push_i),
    .height_i   (height_i),
    .full_o     (full_o),
    .job_o      (fe_job),
    .job_push_o (jq_push),
    .job_full_i (jq_full)
  );

  hmng_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .data_i  (fe_job),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .data_o  (jq_job),
    .empty_o (jq_empty)
  );

  hmng_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_i          (jq_job),
    .job_empty_i    (jq_empty),
    .job_pop_o      (jq_pop),
    .col_o          (col_o),
    .row_o          (row_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .last_of_grid_o (last_of_grid_o),
    .empty_o        (empty_o),
    .pop_i          (pop_i)
  );

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> full_o)
    else $error("front end took a sample without going busy");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_push |-> !jq_full)
    else $error("job pushed into a full queue");

  a_last_not_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && last_of_grid_o) |-> (row_o != '0))
    else $error("last grid point reported on the first row");

endmodule
